// ===== src/i2cm_pkg.sv =====
// shared types and constants for the i2c master bit engine
package i2cm_pkg;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned DATA_BITS = 8;
  localparam int unsigned CNT_W = 4;

  // register word index
  localparam logic REG_STRETCH = 1'b0;

  // request codes
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic       send_start;
    logic       send_stop;
    logic [7:0] write_byte;
    logic       ack_after_read;
    logic       scl_in;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       busy_res;
    logic       done_res;
    logic       nack;
    logic [7:0] read_byte;
  } res_t;

  typedef struct packed {
    logic rd;
    logic stop;
    logic ack;
  } cmd_flags_t;

endpackage

// ===== src/i2cm_intf.sv =====
// valid/ready channel interfaces for requests and results
interface i2cm_req_if;
  import i2cm_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2cm_res_if;
  import i2cm_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/i2c_master_bit_engine.sv =====
// i2c master bit engine: byte sequencer with request and result channels
//
// usage: every request transaction is one tick of the bus sequencer. it
// carries the sampled scl/sda levels and, while idle, an optional write or
// read byte command. each accepted request yields exactly one result
// transaction with the new pin drives, busy, a one-tick done flag, the
// sampled nack of a finished write and the byte of a finished read.
// the stretch_enable register (apb, word 0) selects whether a released scl
// must read high before the sequencer moves on; write it only while idle.
// the result of a request is registered in the output register, or in the
// skid entry while a result waits. one request per cycle while the skid is
// empty; the only loop is the phase/counter/shift update from the accepted request.
// the result side has a two-entry buffer (output register plus skid), so a
// request is still taken while one result waits; ready drops only when both
// entries are full and comes back as soon as the receiver takes one.
// reset: phase idle with both lines released, all counters and flags clear,
// stretch_enable set, result buffer empty.
module i2c_master_bit_engine (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  i2cm_req_if.sink                       req_i,
  i2cm_res_if.source                     res_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [i2cm_pkg::PADDR_W-1:0]   paddr,
  input  logic [i2cm_pkg::PDATA_W-1:0]   pwdata,
  output logic [i2cm_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import i2cm_pkg::*;

  typedef enum logic [11:0] {
    PH_IDLE_FREE      = 12'b0000_0000_0001,
    PH_IDLE_SCL       = 12'b0000_0000_0010,
    PH_IDLE_BOTH      = 12'b0000_0000_0100,
    PH_START_REL_FREE = 12'b0000_0000_1000,
    PH_START_REL_HELD = 12'b0000_0001_0000,
    PH_START_WAIT     = 12'b0000_0010_0000,
    PH_START_FALL     = 12'b0000_0100_0000,
    PH_START_LOW      = 12'b0000_1000_0000,
    PH_BIT_SETUP      = 12'b0001_0000_0000,
    PH_BIT_HIGH       = 12'b0010_0000_0000,
    PH_STOP_LOW       = 12'b0100_0000_0000,
    PH_STOP_WAIT      = 12'b1000_0000_0000
  } phase_e;

  // sda level during a data or ack bit
  function automatic logic bit_sda_low(logic [CNT_W-1:0] cnt, cmd_flags_t fl,
                                       logic [7:0] sh);
    logic r;
    if (cnt < CNT_W'(DATA_BITS)) begin
      r = fl.rd ? 1'b0 : ~sh[7];
    end else begin
      r = fl.rd & fl.ack;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // configuration register
  // ---------------------------------------------------------------------
  logic stretch_q;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[PADDR_W-1] == REG_STRETCH);
  assign prdata = (paddr[PADDR_W-1] == REG_STRETCH) ? {{(PDATA_W-1){1'b0}}, stretch_q}
                                                    : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stretch_q <= 1'b1;
    end else if (cfg_wr) begin
      stretch_q <= pwdata[0];
    end
  end

  // ---------------------------------------------------------------------
  // sequencer state
  // ---------------------------------------------------------------------
  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       shift_q, shift_d;
  logic             started_q, started_d;
  cmd_flags_t       flags_q, flags_d;
  logic             ack_q, ack_d;

  req_t req;
  res_t res;
  logic high_ok;
  logic done;
  logic in_fire;
  logic is_cmd;

  assign req     = req_i.data;
  assign high_ok = ~stretch_q | req.scl_in;
  assign is_cmd  = (req.req_type == REQ_WRITE) || (req.req_type == REQ_READ);

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    shift_d   = shift_q;
    started_d = started_q;
    flags_d   = flags_q;
    ack_d     = ack_q;
    done      = 1'b0;

    unique case (phase_q) inside
      PH_IDLE_FREE, PH_IDLE_SCL, PH_IDLE_BOTH: begin
        if (is_cmd) begin
          cnt_d   = '0;
          ack_d   = 1'b0;
          flags_d = '{rd: (req.req_type == REQ_READ), stop: req.send_stop,
                      ack: req.ack_after_read};
          if (req.req_type == REQ_READ) begin
            shift_d = '0;
            phase_d = PH_BIT_SETUP;
          end else begin
            shift_d = req.write_byte;
            if (req.send_start) begin
              phase_d = (phase_q == PH_IDLE_FREE) ? PH_START_REL_FREE
                                                  : PH_START_REL_HELD;
            end else begin
              phase_d = PH_BIT_SETUP;
            end
          end
        end
      end
      PH_START_REL_FREE: begin
        phase_d = started_q ? PH_START_WAIT : PH_START_FALL;
      end
      PH_START_REL_HELD: begin
        phase_d = started_q ? PH_START_WAIT : PH_START_LOW;
      end
      PH_START_WAIT: begin
        if (high_ok) begin
          phase_d = PH_START_FALL;
        end
      end
      PH_START_FALL: begin
        phase_d = PH_START_LOW;
      end
      PH_START_LOW: begin
        started_d = 1'b1;
        phase_d   = PH_BIT_SETUP;
      end
      PH_BIT_SETUP: begin
        phase_d = PH_BIT_HIGH;
      end
      PH_BIT_HIGH: begin
        if (high_ok) begin
          if (cnt_q < CNT_W'(DATA_BITS)) begin
            shift_d = {shift_q[6:0], flags_q.rd & req.sda_in};
            cnt_d   = cnt_q + CNT_W'(1);
            phase_d = PH_BIT_SETUP;
          end else begin
            if (!flags_q.rd) begin
              ack_d = req.sda_in;
            end
            if (flags_q.stop) begin
              phase_d = PH_STOP_LOW;
            end else begin
              // idle keeps scl low; sda stays low only after an acked read
              phase_d = bit_sda_low(cnt_q, flags_q, shift_q) ? PH_IDLE_BOTH
                                                             : PH_IDLE_SCL;
              done    = 1'b1;
            end
          end
        end
      end
      PH_STOP_LOW: begin
        phase_d = PH_STOP_WAIT;
      end
      PH_STOP_WAIT: begin
        if (high_ok) begin
          started_d = 1'b0;
          phase_d   = PH_IDLE_FREE;
          done      = 1'b1;
        end
      end
      default: begin
        phase_d = PH_IDLE_FREE;
      end
    endcase
  end

  // result from the updated state
  always_comb begin
    res           = '0;
    res.busy_res  = ~((phase_d == PH_IDLE_FREE) || (phase_d == PH_IDLE_SCL) ||
                      (phase_d == PH_IDLE_BOTH));
    res.done_res  = done;
    res.nack      = done & ~flags_d.rd & ack_d;
    res.read_byte = (done & flags_d.rd) ? shift_d : 8'h00;
    unique case (phase_d)
      PH_IDLE_SCL:       begin res.scl_drive_low = 1'b1; res.sda_drive_low = 1'b0; end
      PH_IDLE_BOTH:      begin res.scl_drive_low = 1'b1; res.sda_drive_low = 1'b1; end
      PH_START_REL_HELD: begin res.scl_drive_low = 1'b1; res.sda_drive_low = 1'b0; end
      PH_START_FALL:     begin res.scl_drive_low = 1'b0; res.sda_drive_low = 1'b1; end
      PH_START_LOW:      begin res.scl_drive_low = 1'b1; res.sda_drive_low = 1'b1; end
      PH_BIT_SETUP: begin
        res.scl_drive_low = 1'b1;
        res.sda_drive_low = bit_sda_low(cnt_d, flags_d, shift_d);
      end
      PH_BIT_HIGH: begin
        res.scl_drive_low = 1'b0;
        res.sda_drive_low = bit_sda_low(cnt_d, flags_d, shift_d);
      end
      PH_STOP_LOW:       begin res.scl_drive_low = 1'b1; res.sda_drive_low = 1'b1; end
      PH_STOP_WAIT:      begin res.scl_drive_low = 1'b0; res.sda_drive_low = 1'b1; end
      default:           begin res.scl_drive_low = 1'b0; res.sda_drive_low = 1'b0; end
    endcase
  end

  // state advances once per accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE_FREE;
      cnt_q     <= '0;
      shift_q   <= '0;
      started_q <= 1'b0;
      flags_q   <= '0;
      ack_q     <= 1'b0;
    end else if (in_fire) begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      shift_q   <= shift_d;
      started_q <= started_d;
      flags_q   <= flags_d;
      ack_q     <= ack_d;
    end
  end

  // ---------------------------------------------------------------------
  // result buffer: output register plus skid entry
  // ---------------------------------------------------------------------
  logic out_vld_q, skid_vld_q;
  res_t out_q, skid_q;
  logic out_fire;

  assign req_i.ready = ~skid_vld_q;
  assign in_fire     = req_i.valid & ~skid_vld_q;
  assign out_fire    = out_vld_q & res_o.ready;
  assign res_o.valid = out_vld_q;
  assign res_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (in_fire) begin
      // skid is empty here
      if (!out_vld_q || res_o.ready) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (out_fire) begin
      if (skid_vld_q) begin
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (!out_vld_q || res_o.ready) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if (out_fire && skid_vld_q) begin
      out_q <= skid_q;
    end
  end

endmodule

// ===== tb/i2cm_checker.sv =====
// checker for the i2c master bit engine: tick-level prediction and result comparison
`timescale 1ns / 1ps

module i2cm_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  i2cm_req_if                          req_mon,
  i2cm_res_if                          res_mon,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [i2cm_pkg::PADDR_W-1:0] paddr,
  input  logic [i2cm_pkg::PDATA_W-1:0] pwdata,
  input  logic                         pready,
  output int                           fail_count,
  output int                           pending
);
  import i2cm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_IDLE_SCL_LO,
    S_IDLE_BOTH_LO,
    S_RS_FREE,
    S_RS_HELD,
    S_START_WAIT,
    S_START_FALL,
    S_START_LOW,
    S_BIT_SETUP,
    S_BIT_HIGH,
    S_STOP_LOW,
    S_STOP_WAIT
  } seq_state_e;

  // engine copy
  logic         stretch_en;
  seq_state_e   st;
  logic [3:0]   bit_cnt;
  logic [7:0]   shreg;
  logic         start_done;
  cmd_flags_t   flags;
  logic         ack_smp;

  res_t         drive_q[$];
  int           fails = 0;
  int           depth = 0;

  assign fail_count = fails;
  assign pending    = depth;

  // sda level wanted during the current bit slot
  function automatic logic slot_sda_low();
    if (bit_cnt < 4'(DATA_BITS)) begin
      return flags.rd ? 1'b0 : ~shreg[7];
    end
    return flags.rd & flags.ack;
  endfunction

  // advance one tick and return the pin/status word seen after it
  function automatic res_t tick_engine(req_t r);
    res_t o;
    logic scl_ok;
    logic fin;
    o      = '0;
    fin    = 1'b0;
    scl_ok = !stretch_en || r.scl_in;
    case (st) inside
      S_IDLE, S_IDLE_SCL_LO, S_IDLE_BOTH_LO: begin
        if (r.req_type == REQ_WRITE || r.req_type == REQ_READ) begin
          bit_cnt    = '0;
          ack_smp    = 1'b0;
          flags.rd   = (r.req_type == REQ_READ);
          flags.stop = r.send_stop;
          flags.ack  = r.ack_after_read;
          if (flags.rd) begin
            shreg = '0;
            st    = S_BIT_SETUP;
          end else begin
            shreg = r.write_byte;
            if (r.send_start) begin
              st = (st == S_IDLE) ? S_RS_FREE : S_RS_HELD;
            end else begin
              st = S_BIT_SETUP;
            end
          end
        end
      end
      S_RS_FREE:    st = start_done ? S_START_WAIT : S_START_FALL;
      S_RS_HELD:    st = start_done ? S_START_WAIT : S_START_LOW;
      S_START_WAIT: if (scl_ok) st = S_START_FALL;
      S_START_FALL: st = S_START_LOW;
      S_START_LOW: begin
        start_done = 1'b1;
        st         = S_BIT_SETUP;
      end
      S_BIT_SETUP:  st = S_BIT_HIGH;
      S_BIT_HIGH: begin
        if (scl_ok) begin
          if (bit_cnt < 4'(DATA_BITS)) begin
            shreg   = {shreg[6:0], flags.rd & r.sda_in};
            bit_cnt = bit_cnt + 4'd1;
            st      = S_BIT_SETUP;
          end else begin
            if (!flags.rd) ack_smp = r.sda_in;
            if (flags.stop) begin
              st = S_STOP_LOW;
            end else begin
              st  = slot_sda_low() ? S_IDLE_BOTH_LO : S_IDLE_SCL_LO;
              fin = 1'b1;
            end
          end
        end
      end
      S_STOP_LOW:   st = S_STOP_WAIT;
      S_STOP_WAIT: begin
        if (scl_ok) begin
          start_done = 1'b0;
          st         = S_IDLE;
          fin        = 1'b1;
        end
      end
      default:      st = S_IDLE;
    endcase

    if (fin) begin
      if (flags.rd) o.read_byte = shreg;
      else          o.nack      = ack_smp;
    end

    case (st)
      S_IDLE_SCL_LO:  {o.scl_drive_low, o.sda_drive_low} = 2'b10;
      S_IDLE_BOTH_LO: {o.scl_drive_low, o.sda_drive_low} = 2'b11;
      S_RS_HELD:      {o.scl_drive_low, o.sda_drive_low} = 2'b10;
      S_START_FALL:   {o.scl_drive_low, o.sda_drive_low} = 2'b01;
      S_START_LOW:    {o.scl_drive_low, o.sda_drive_low} = 2'b11;
      S_BIT_SETUP:    {o.scl_drive_low, o.sda_drive_low} = {1'b1, slot_sda_low()};
      S_BIT_HIGH:     {o.scl_drive_low, o.sda_drive_low} = {1'b0, slot_sda_low()};
      S_STOP_LOW:     {o.scl_drive_low, o.sda_drive_low} = 2'b11;
      S_STOP_WAIT:    {o.scl_drive_low, o.sda_drive_low} = 2'b01;
      default:        {o.scl_drive_low, o.sda_drive_low} = 2'b00;
    endcase
    o.busy_res = (st != S_IDLE) && (st != S_IDLE_SCL_LO) && (st != S_IDLE_BOTH_LO);
    o.done_res = fin;
    return o;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      stretch_en = 1'b1;
      st         = S_IDLE;
      bit_cnt    = '0;
      shreg      = '0;
      start_done = 1'b0;
      flags      = '0;
      ack_smp    = 1'b0;
      drive_q.delete();
      depth      = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == {REG_STRETCH, 2'b00}) begin
        stretch_en = pwdata[0];
      end
      if (req_mon.valid && req_mon.ready) begin
        drive_q.push_back(tick_engine(req_mon.data));
      end
      if (res_mon.valid && res_mon.ready) begin
        if (drive_q.size() == 0) begin
          $error("result transaction with no expectation waiting");
          fails++;
        end else begin
          want = drive_q.pop_front();
          check_field("scl_drive_low", 8'(want.scl_drive_low), 8'(res_mon.data.scl_drive_low));
          check_field("sda_drive_low", 8'(want.sda_drive_low), 8'(res_mon.data.sda_drive_low));
          check_field("busy_res", 8'(want.busy_res), 8'(res_mon.data.busy_res));
          check_field("done_res", 8'(want.done_res), 8'(res_mon.data.done_res));
          check_field("nack", 8'(want.nack), 8'(res_mon.data.nack));
          check_field("read_byte", want.read_byte, res_mon.data.read_byte);
        end
      end
      depth = drive_q.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// top of the i2c master bit engine testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;
  import i2cm_pkg::*;

  // request code the engine must treat as a plain tick
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  // byte address of the stretch register
  localparam logic [PADDR_W-1:0] ADDR_STRETCH = {REG_STRETCH, 2'b00};
  // random ticks per traffic phase, four phases
  localparam int TICKS_PER_PHASE = 100;
  // generous ceiling on the run length for the watchdog
  localparam int CYCLE_LIMIT = 200000;
  // length of the forced result back-pressure
  localparam int LONG_HOLD = 80;

  logic clk_i;
  logic rst_ni;

  // apb configuration port
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  i2cm_req_if req_ch ();
  i2cm_res_if res_ch ();

  // knobs for the idling processes, written by the stimulus only
  int idle_pct = 0;
  int stall_pct = 0;
  int holds_asked = 0;

  int fail_count;
  int pending;
  int cycle_cnt;
  // busy flag of the newest result taken, used to run a command out
  bit last_busy = 1'b0;

  i2c_master_bit_engine dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_ch),
    .res_o   (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  i2cm_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_mon    (req_ch),
    .res_mon    (res_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAIL i2c_master_bit_engine");
    $finish;
  end

  // result side: random stalls, plus one long hold when asked for
  initial begin
    int holds_served;
    int hold_left;
    holds_served = 0;
    hold_left    = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holds_served < holds_asked) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (res_ch.valid && res_ch.ready) last_busy <= res_ch.data.busy_res;
  end

  function automatic req_t mk_req(logic [1:0] kind, logic start, logic stop, logic [7:0] wb,
                                  logic ack, logic scl, logic sda);
    req_t r;
    r.req_type       = kind;
    r.send_start     = start;
    r.send_stop      = stop;
    r.write_byte     = wb;
    r.ack_after_read = ack;
    r.scl_in         = scl;
    r.sda_in         = sda;
    return r;
  endfunction

  // mostly plain ticks with a fair share of commands, so that commands
  // land both on an idle engine and on a busy one
  function automatic req_t rand_tick();
    logic [1:0] kind;
    logic [7:0] wb;
    int         pick;
    kind = REQ_TICK;
    if ($urandom_range(0, 99) < 30) begin
      pick = $urandom_range(0, 9);
      if (pick < 5)      kind = REQ_WRITE;
      else if (pick < 9) kind = REQ_READ;
      else               kind = REQ_UNUSED;
    end
    pick = $urandom_range(0, 9);
    if (pick == 0)      wb = 8'h00;
    else if (pick == 1) wb = 8'hFF;
    else                wb = 8'($urandom_range(0, 255));
    // scl mostly reads high so stretching phases make progress
    return mk_req(kind, $urandom_range(0, 99) < 60, 1'($urandom_range(0, 1)), wb,
                  1'($urandom_range(0, 1)), $urandom_range(0, 99) < 75,
                  1'($urandom_range(0, 1)));
  endfunction

  // offer one tick, with random idle cycles ahead of it; returns at a falling edge
  task automatic push_req(input req_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // drain all results, then feed plain ticks with scl high until no command runs
  task automatic settle();
    forever begin
      req_ch.valid <= 1'b0;
      while (pending != 0) @(posedge clk_i);
      @(negedge clk_i);
      if (!last_busy) break;
      push_req(mk_req(REQ_TICK, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1));
    end
    repeat (3) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    apb_write(ADDR_STRETCH, 32'd1);

    // directed: an unused request code is only a tick
    push_req(mk_req(REQ_UNUSED, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b1));
    // read with start asked (start ignored), no stop, acknowledged
    push_req(mk_req(REQ_READ, 1'b1, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0));
    // a write while busy must be dropped
    push_req(mk_req(REQ_WRITE, 1'b1, 1'b1, 8'hFF, 1'b0, 1'b0, 1'b1));
    // first high phase sees scl held low by a stretching target
    for (int k = 0; k < 19; k++) begin
      push_req(mk_req(REQ_TICK, 1'b0, 1'b0, 8'h00, 1'b0, k != 0, k[1] ^ k[2]));
    end
    // start from idle with scl still held low after the unstopped read
    push_req(mk_req(REQ_WRITE, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0));

    // traffic phases: stretch off/on, and each idling pattern
    for (int p = 0; p < 4; p++) begin
      settle();
      apb_write(ADDR_STRETCH, p[0] ? 32'd1 : 32'd0);
      case (p)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
          // long result hold while ticks keep coming: fills the result buffer
          holds_asked++;
        end
        1: begin
          idle_pct  = 67;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 67;
        end
        default: begin
          idle_pct  = 19;
          stall_pct = 19;
        end
      endcase
      for (int n = 0; n < TICKS_PER_PHASE; n++) push_req(rand_tick());
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS i2c_master_bit_engine");
    end else begin
      $display("FAIL i2c_master_bit_engine");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/i2cm_pkg.sv
src/i2cm_intf.sv
src/i2c_master_bit_engine.sv
tb/i2cm_checker.sv
tb/testbench.sv
